// ----- sv/arpb_pkg.sv -----
// ----------------------------------------------------------------------------
// arpb_pkg
// Shared types and constants of the stereo jitter FIFO with drop-oldest
// overflow and prebuffer gate.
// ----------------------------------------------------------------------------
package arpb_pkg;

  localparam int KIND_W   = 2;
  localparam int SAMPLE_W = 16;
  localparam int FRAME_W  = 2 * SAMPLE_W;
  localparam int FILL_W   = 12;
  localparam int PREBUF_W = 12;

  localparam logic [PREBUF_W-1:0] PREBUF_RESET = 12'd480;

  // command codes of one input item
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_PULL  = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_t;

  // per-item status handed from the pointer logic to the result pipeline
  typedef struct packed {
    logic              took;
    logic              dropped;
    logic [FILL_W-1:0] fill;
    logic              primed;
  } ctrl_res_t;

endpackage

// ----- sv/arpb_in_if.sv -----
// ----------------------------------------------------------------------------
// arpb_in_if
// Command channel: push, pull or flush with one stereo frame of payload.
// ----------------------------------------------------------------------------
interface arpb_in_if import arpb_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic signed [SAMPLE_W-1:0] left_in;
  logic signed [SAMPLE_W-1:0] right_in;

  modport source (output valid, kind, left_in, right_in, input ready);
  modport sink   (input valid, kind, left_in, right_in, output ready);
endinterface

// ----- sv/arpb_out_if.sv -----
// ----------------------------------------------------------------------------
// arpb_out_if
// Result channel: one result per command with samples, flags and fill.
// ----------------------------------------------------------------------------
interface arpb_out_if import arpb_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       from_store;
  logic                       dropped_oldest;
  logic [FILL_W-1:0]          fill_level;
  logic                       is_primed;

  modport source (output valid, left_out, right_out, from_store, dropped_oldest,
                  fill_level, is_primed, input ready);
  modport sink   (input valid, left_out, right_out, from_store, dropped_oldest,
                  fill_level, is_primed, output ready);
endinterface

// ----- sv/arpb_ram.sv -----
// ----------------------------------------------------------------------------
// arpb_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module arpb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/arpb_ctrl.sv -----
// ----------------------------------------------------------------------------
// arpb_ctrl
// Read pointer, frame count and primed flag; decides the store write and read
// for each accepted command and reports the status after it.
// ----------------------------------------------------------------------------
module arpb_ctrl import arpb_pkg::*; #(
  parameter int STORE_FRAMES = 2048,
  localparam int AW = $clog2(STORE_FRAMES),
  localparam int CW = $clog2(STORE_FRAMES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic [KIND_W-1:0]          kind,
  input  logic signed [SAMPLE_W-1:0] left_in,
  input  logic signed [SAMPLE_W-1:0] right_in,
  input  logic [PREBUF_W-1:0]        prebuf,
  output logic                       ram_we,
  output logic [AW-1:0]              ram_waddr,
  output logic [FRAME_W-1:0]         ram_wdata,
  output logic                       ram_re,
  output logic [AW-1:0]              ram_raddr,
  output ctrl_res_t                  res
);

  localparam int SW = CW + 1;
  localparam int TW = (CW > PREBUF_W) ? CW : PREBUF_W;

  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          primed_r, primed_nxt;

  logic          full;
  logic          avail;
  logic [AW-1:0] rp_inc;
  logic [SW-1:0] wsum;
  logic [SW-1:0] wsum_wrap;
  logic [TW-1:0] thr;
  logic [CW-1:0] cnt_push;
  logic          took;
  logic          dropped;

  // pointer arithmetic and threshold clamp
  always_comb begin
    full      = (cnt_r == CW'(STORE_FRAMES));
    avail     = primed_r && (cnt_r != '0);
    rp_inc    = (rp_r == AW'(STORE_FRAMES - 1)) ? '0 : rp_r + 1'b1;
    wsum      = SW'(rp_r) + SW'(cnt_r);
    wsum_wrap = (wsum >= SW'(STORE_FRAMES)) ? wsum - SW'(STORE_FRAMES) : wsum;
    thr       = (TW'(prebuf) > TW'(STORE_FRAMES)) ? TW'(STORE_FRAMES) : TW'(prebuf);
    cnt_push  = full ? cnt_r : cnt_r + 1'b1;
  end

  // next state per command
  always_comb begin
    rp_nxt     = rp_r;
    cnt_nxt    = cnt_r;
    primed_nxt = primed_r;
    took       = 1'b0;
    dropped    = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    // a full store overwrites the oldest slot, which sits at the read pointer
    ram_waddr  = full ? rp_r : wsum_wrap[AW-1:0];
    ram_wdata  = {right_in, left_in};
    ram_raddr  = rp_r;
    case (kind_t'(kind))
      KIND_PUSH: begin
        ram_we     = fire;
        dropped    = full;
        rp_nxt     = full ? rp_inc : rp_r;
        cnt_nxt    = cnt_push;
        primed_nxt = primed_r || (TW'(cnt_push) >= thr);
      end
      KIND_PULL: begin
        if (avail) begin
          took       = 1'b1;
          ram_re     = fire;
          rp_nxt     = rp_inc;
          cnt_nxt    = cnt_r - 1'b1;
          primed_nxt = (cnt_r != CW'(1));
        end
      end
      KIND_FLUSH: begin
        rp_nxt     = '0;
        cnt_nxt    = '0;
        primed_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // status after this command
  always_comb begin
    res.took    = took;
    res.dropped = dropped;
    res.fill    = FILL_W'(cnt_nxt);
    res.primed  = primed_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r     <= '0;
      cnt_r    <= '0;
      primed_r <= 1'b0;
    end else if (fire) begin
      rp_r     <= rp_nxt;
      cnt_r    <= cnt_nxt;
      primed_r <= primed_nxt;
    end
  end

endmodule

// ----- sv/arpb_pipe.sv -----
// ----------------------------------------------------------------------------
// arpb_pipe
// Result pipeline: a status stage that waits for the store read data, then
// the output register that drives the result channel.
// ----------------------------------------------------------------------------
module arpb_pipe import arpb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  ctrl_res_t          res,
  input  logic [FRAME_W-1:0] rdata,
  output logic               in_ready,
  arpb_out_if.source         out_res
);

  logic      s1_valid_r, s1_valid_nxt;
  ctrl_res_t s1_res_r;
  logic      out_valid_r, out_valid_nxt;
  logic      adv;

  logic signed [SAMPLE_W-1:0] left_r, right_r;
  logic                       took_r, dropped_r, primed_r;
  logic [FILL_W-1:0]          fill_r;

  // handshake: status stage moves whenever the output register is free
  always_comb begin
    adv           = !out_valid_r || out_res.ready;
    in_ready      = !s1_valid_r || adv;
    s1_valid_nxt  = fire || (s1_valid_r && !adv);
    out_valid_nxt = (s1_valid_r && adv) || (out_valid_r && !out_res.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // status stage
  always_ff @(posedge clk) begin
    if (fire) begin
      s1_res_r <= res;
    end
  end

  // output register, silence unless a frame was taken
  always_ff @(posedge clk) begin
    if (s1_valid_r && adv) begin
      left_r    <= s1_res_r.took ? rdata[SAMPLE_W-1:0] : '0;
      right_r   <= s1_res_r.took ? rdata[FRAME_W-1:SAMPLE_W] : '0;
      took_r    <= s1_res_r.took;
      dropped_r <= s1_res_r.dropped;
      fill_r    <= s1_res_r.fill;
      primed_r  <= s1_res_r.primed;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.left_out       = left_r;
  assign out_res.right_out      = right_r;
  assign out_res.from_store     = took_r;
  assign out_res.dropped_oldest = dropped_r;
  assign out_res.fill_level     = fill_r;
  assign out_res.is_primed      = primed_r;

endmodule

// ----- sv/audio_ring_drop_oldest_prebuffer.sv -----
// ----------------------------------------------------------------------------
// audio_ring_drop_oldest_prebuffer
// Stereo PCM jitter FIFO with drop-oldest overflow and a prebuffer gate.
// ----------------------------------------------------------------------------
// One command is accepted per clock (push, pull or flush) and each gives one
// result. Its result passes the registered read of the frame RAM, held with
// its status in the status stage, and then the output register. Pointer,
// count and primed flag update in the cycle of the transfer, so consecutive
// commands never wait on each other; only a stalled result channel holds off
// input once both pipeline stages are full. The frame RAM needs no clearing
// after reset and the block takes commands right out of reset.
module audio_ring_drop_oldest_prebuffer import arpb_pkg::*; #(
  parameter int STORE_FRAMES = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  arpb_in_if.sink             in_item,
  arpb_out_if.source          out_res,
  input  logic                cfg_we,
  input  logic [PREBUF_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(STORE_FRAMES);

  logic [PREBUF_W-1:0] prebuf_r;
  logic                fire;
  logic                in_ready;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [FRAME_W-1:0]  ram_wdata, ram_rdata;
  ctrl_res_t           res;

  // prebuffer threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prebuf_r <= PREBUF_RESET;
    end else if (cfg_we) begin
      prebuf_r <= cfg_wdata;
    end
  end

  assign fire          = in_item.valid && in_ready;
  assign in_item.ready = in_ready;

  // pointer and fill control
  arpb_ctrl #(
    .STORE_FRAMES (STORE_FRAMES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .kind      (in_item.kind),
    .left_in   (in_item.left_in),
    .right_in  (in_item.right_in),
    .prebuf    (prebuf_r),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .res       (res)
  );

  // frame store
  arpb_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (STORE_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result pipeline
  arpb_pipe u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .res      (res),
    .rdata    (ram_rdata),
    .in_ready (in_ready),
    .out_res  (out_res)
  );

endmodule
